FILE: hdl/rbsi_pkg.sv
// ----------------------------------------------------------------------------
// rbsi_pkg
// Shared widths, register indexes and types of the ray/box slab intersector.
// ----------------------------------------------------------------------------
package rbsi_pkg;

  // Coordinate format: signed fixed point with FRAC fraction bits.
  localparam int CW     = 32;
  localparam int FRAC   = 16;
  localparam int NUM_W  = CW + 1;
  localparam int DIST_W = 31;
  localparam int IDX_W  = 3;

  // Largest quotient magnitude, 2^(CW-1)-1.
  localparam logic [CW-2:0] MAXV = {(CW-1){1'b1}};

  // Box corner reset values: the unit cube.
  localparam logic [CW-1:0] ZERO_FX = '0;
  localparam logic [CW-1:0] ONE_FX  = CW'(1) << FRAC;

  // Pipeline depths.
  localparam int DIV_LAT   = CW + 1;
  localparam int LANE_LAT  = DIV_LAT + 1;
  localparam int MERGE_LAT = 3;
  localparam int PIPE_LAT  = LANE_LAT + MERGE_LAT;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_MIN_X = 3'd0;
  localparam logic [IDX_W-1:0] REG_MIN_Y = 3'd1;
  localparam logic [IDX_W-1:0] REG_MIN_Z = 3'd2;
  localparam logic [IDX_W-1:0] REG_MAX_X = 3'd3;
  localparam logic [IDX_W-1:0] REG_MAX_Y = 3'd4;
  localparam logic [IDX_W-1:0] REG_MAX_Z = 3'd5;

  // Entry and exit parameters of one axis.
  typedef struct packed {
    logic signed [CW-1:0] tnear;
    logic signed [CW-1:0] tfar;
  } slab_t;

endpackage

FILE: hdl/rbsi_ray_if.sv
// ----------------------------------------------------------------------------
// rbsi_ray_if
// Ray request channel: origin and direction with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface rbsi_ray_if;
  logic        valid;
  logic        ready;
  logic [31:0] dir_x;
  logic [31:0] dir_y;
  logic [31:0] dir_z;
  logic [31:0] origin_x;
  logic [31:0] origin_y;
  logic [31:0] origin_z;

  modport source (output valid, dir_x, dir_y, dir_z, origin_x, origin_y, origin_z,
                  input ready);
  modport sink (input valid, dir_x, dir_y, dir_z, origin_x, origin_y, origin_z,
                output ready);
endinterface

FILE: hdl/rbsi_hit_if.sv
// ----------------------------------------------------------------------------
// rbsi_hit_if
// Result channel: hit flag and distance with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface rbsi_hit_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [30:0] distance;

  modport source (output valid, hit, distance, input ready);
  modport sink (input valid, hit, distance, output ready);
endinterface

FILE: hdl/ray_box_slab_intersect.sv
// ----------------------------------------------------------------------------
// ray_box_slab_intersect
// Ray versus axis-aligned box test in signed Q16.16 by the slab method.
// ----------------------------------------------------------------------------
// Accepts one ray per clock and returns one result per ray, in order. Three
// axis lanes each run two pipelined dividers that produce one quotient bit
// per stage, so a ray passes 37 register stages (one offset stage, 33 divider
// stages, three merge stages) before its result is offered; throughput is one
// ray per cycle. The whole pipeline stalls only while a finished result waits
// and the result side is not ready. Box corners are written through wr_en,
// wr_index and wr_data; the user must write them only while no ray is in
// flight, as the block does not enforce it. They reset to the unit cube.
module ray_box_slab_intersect
  import rbsi_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_index,
  input  logic [CW-1:0]     wr_data,
  rbsi_ray_if.sink          ray,
  rbsi_hit_if.source        result
);

  logic [CW-1:0] box_min_x;
  logic [CW-1:0] box_min_y;
  logic [CW-1:0] box_min_z;
  logic [CW-1:0] box_max_x;
  logic [CW-1:0] box_max_y;
  logic [CW-1:0] box_max_z;

  logic [PIPE_LAT-1:0] vld;
  logic                en;
  slab_t               sx;
  slab_t               sy;
  slab_t               sz;

  // Box corner registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      box_min_x <= ZERO_FX;
      box_min_y <= ZERO_FX;
      box_min_z <= ZERO_FX;
      box_max_x <= ONE_FX;
      box_max_y <= ONE_FX;
      box_max_z <= ONE_FX;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_MIN_X: box_min_x <= wr_data;
        REG_MIN_Y: box_min_y <= wr_data;
        REG_MIN_Z: box_min_z <= wr_data;
        REG_MAX_X: box_max_x <= wr_data;
        REG_MAX_Y: box_max_y <= wr_data;
        REG_MAX_Z: box_max_z <= wr_data;
        default: ;
      endcase
    end
  end

  // The pipeline advances unless a finished result is held.
  assign en           = !vld[PIPE_LAT-1] || result.ready;
  assign ray.ready    = en;
  assign result.valid = vld[PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_LAT-2:0], ray.valid};
    end
  end

  // One lane per axis.
  rbsi_lane u_lane_x (
    .clk  (clk),
    .en   (en),
    .lo   (box_min_x),
    .hi   (box_max_x),
    .org  (ray.origin_x),
    .dir  (ray.dir_x),
    .slab (sx)
  );

  rbsi_lane u_lane_y (
    .clk  (clk),
    .en   (en),
    .lo   (box_min_y),
    .hi   (box_max_y),
    .org  (ray.origin_y),
    .dir  (ray.dir_y),
    .slab (sy)
  );

  rbsi_lane u_lane_z (
    .clk  (clk),
    .en   (en),
    .lo   (box_min_z),
    .hi   (box_max_z),
    .org  (ray.origin_z),
    .dir  (ray.dir_z),
    .slab (sz)
  );

  // Interval merge; its last stage is the output register.
  rbsi_merge u_merge (
    .clk      (clk),
    .en       (en),
    .sx       (sx),
    .sy       (sy),
    .sz       (sz),
    .hit      (result.hit),
    .distance (result.distance)
  );

endmodule

FILE: hdl/rbsi_div.sv
// ----------------------------------------------------------------------------
// rbsi_div
// Pipelined saturating fixed-point divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rbsi_div
  import rbsi_pkg::*;
(
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [NUM_W-1:0] num,
  input  logic signed [CW-1:0]    den,
  output logic signed [CW-1:0]    quo
);

  logic [NUM_W-1:0]   num_abs;
  logic [CW-1:0]      den_abs;
  logic [CW+FRAC-1:0] nm;
  logic [CW-1:0]      nm_top;
  logic               sat_in;
  logic               neg_in;

  logic [CW-1:0] rem   [CW];
  logic [CW-2:0] low   [CW];
  logic [CW-2:0] qbits [CW];
  logic [CW-1:0] dm    [CW];
  logic          neg   [CW];
  logic          sat   [CW];

  logic [CW-2:0] qmag;

  // Magnitudes and the overflow test: the quotient overflows when the
  // scaled numerator reaches the divisor times 2^(CW-1).
  always_comb begin
    num_abs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    den_abs = den[CW-1] ? CW'(-den) : CW'(den);
    nm      = {num_abs[CW-1:0], {FRAC{1'b0}}};
    nm_top  = CW'(nm[CW+FRAC-1:CW-1]);
    sat_in  = (den == '0) || (nm_top >= den_abs);
    neg_in  = (den == '0) ? num[NUM_W-1] : (num[NUM_W-1] != den[CW-1]);
  end

  // Setup stage.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]   <= nm_top;
      low[0]   <= nm[CW-2:0];
      qbits[0] <= '0;
      dm[0]    <= den_abs;
      neg[0]   <= neg_in;
      sat[0]   <= sat_in;
    end
  end

  // Restoring division stages, most significant quotient bit first.
  for (genvar s = 1; s < CW; s++) begin : g_stage
    logic [CW:0] trial;
    logic [CW:0] diff;
    logic        ge;

    always_comb begin
      trial = {rem[s-1], low[s-1][CW-2]};
      diff  = trial - {1'b0, dm[s-1]};
      ge    = trial >= {1'b0, dm[s-1]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s]   <= ge ? diff[CW-1:0] : trial[CW-1:0];
        low[s]   <= {low[s-1][CW-3:0], 1'b0};
        qbits[s] <= {qbits[s-1][CW-3:0], ge};
        dm[s]    <= dm[s-1];
        neg[s]   <= neg[s-1];
        sat[s]   <= sat[s-1];
      end
    end
  end

  // Saturate and apply the sign.
  assign qmag = sat[CW-1] ? MAXV : qbits[CW-1];

  always_ff @(posedge clk) begin
    if (en) begin
      quo <= neg[CW-1] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
    end
  end

endmodule

FILE: hdl/rbsi_lane.sv
// ----------------------------------------------------------------------------
// rbsi_lane
// One axis of the slab test: plane offsets, plane swap and two dividers.
// ----------------------------------------------------------------------------
module rbsi_lane
  import rbsi_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [CW-1:0]     lo,
  input  logic [CW-1:0]     hi,
  input  logic [CW-1:0]     org,
  input  logic [CW-1:0]     dir,
  output slab_t             slab
);

  logic signed [NUM_W-1:0] a;
  logic signed [NUM_W-1:0] b;
  logic signed [NUM_W-1:0] near_num;
  logic signed [NUM_W-1:0] far_num;
  logic signed [CW-1:0]    dir_q;

  // Offsets of the two planes from the origin; a negative direction swaps them.
  always_comb begin
    a = $signed({lo[CW-1], lo}) - $signed({org[CW-1], org});
    b = $signed({hi[CW-1], hi}) - $signed({org[CW-1], org});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      near_num <= dir[CW-1] ? b : a;
      far_num  <= dir[CW-1] ? a : b;
      dir_q    <= $signed(dir);
    end
  end

  rbsi_div u_div_near (
    .clk (clk),
    .en  (en),
    .num (near_num),
    .den (dir_q),
    .quo (slab.tnear)
  );

  rbsi_div u_div_far (
    .clk (clk),
    .en  (en),
    .num (far_num),
    .den (dir_q),
    .quo (slab.tfar)
  );

endmodule

FILE: hdl/rbsi_merge.sv
// ----------------------------------------------------------------------------
// rbsi_merge
// Intersects the three axis intervals and picks the hit distance.
// ----------------------------------------------------------------------------
module rbsi_merge
  import rbsi_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  slab_t             sx,
  input  slab_t             sy,
  input  slab_t             sz,
  output logic              hit,
  output logic [DIST_W-1:0] distance
);

  logic                 ok1;
  logic signed [CW-1:0] tn1;
  logic signed [CW-1:0] tf1;
  slab_t                z1;
  logic                 ok2;
  logic signed [CW-1:0] tn2;
  logic signed [CW-1:0] tf2;

  // Combine the x and y intervals.
  always_ff @(posedge clk) begin
    if (en) begin
      ok1 <= !((sx.tnear > sy.tfar) || (sy.tnear > sx.tfar));
      tn1 <= (sy.tnear > sx.tnear) ? sy.tnear : sx.tnear;
      tf1 <= (sy.tfar < sx.tfar) ? sy.tfar : sx.tfar;
      z1  <= sz;
    end
  end

  // Fold in the z interval.
  always_ff @(posedge clk) begin
    if (en) begin
      ok2 <= ok1 && !((tn1 > z1.tfar) || (z1.tnear > tf1));
      tn2 <= (z1.tnear > tn1) ? z1.tnear : tn1;
      tf2 <= (z1.tfar < tf1) ? z1.tfar : tf1;
    end
  end

  // Entry distance when it lies ahead, else the exit distance from inside.
  // Quotients saturate at the largest distance, so no further clamp is needed.
  always_ff @(posedge clk) begin
    if (en) begin
      hit <= ok2 && (tf2 > 0);
      if (!(ok2 && (tf2 > 0))) begin
        distance <= '0;
      end else if (tn2 > 0) begin
        distance <= tn2[DIST_W-1:0];
      end else begin
        distance <= tf2[DIST_W-1:0];
      end
    end
  end

endmodule

FILE: tb/tb_ray_box_slab_intersect.sv
// ----------------------------------------------------------------------------
// tb_ray_box_slab_intersect
// Self-checking bench for the ray/box slab intersector. Rays are sent
// through the request channel while the result side stalls at random in some
// phases. A scoreboard predicts hit and distance for every accepted ray from
// its own copy of the box corners and checks results in order.
// ----------------------------------------------------------------------------
module tb_ray_box_slab_intersect;
  import rbsi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint QMAX       = (longint'(1) << (CW - 1)) - 1;
  localparam int     CYCLE_CAP  = 600000;
  localparam int     DRAIN_WAIT = PIPE_LAT + 8;

  typedef struct {
    logic [31:0] dir_x, dir_y, dir_z;
    logic [31:0] org_x, org_y, org_z;
  } ray_t;

  typedef struct {
    logic        hit;
    logic [30:0] distance;
  } hit_t;

  // Scoreboard: box copy, hit predictor and queue of pending hit results.
  class hit_scoreboard;
    logic signed [CW-1:0] corner[6];
    hit_t                 pending[$];
    int                   errors;

    function new();
      reset_box();
      errors = 0;
    endfunction

    function void reset_box();
      corner[REG_MIN_X] = ZERO_FX;
      corner[REG_MIN_Y] = ZERO_FX;
      corner[REG_MIN_Z] = ZERO_FX;
      corner[REG_MAX_X] = ONE_FX;
      corner[REG_MAX_Y] = ONE_FX;
      corner[REG_MAX_Z] = ONE_FX;
    endfunction

    function void write_corner(logic [IDX_W-1:0] idx, logic [CW-1:0] val);
      if (idx <= REG_MAX_Z) corner[idx] = val;
    endfunction

    // Saturating Q16.16 quotient truncated toward zero.
    function longint quotient(longint num, longint den);
      longint nm, dm, q;
      if (den == 0) return (num >= 0) ? QMAX : -QMAX;
      nm = ((num < 0) ? -num : num) <<< FRAC;
      dm = (den < 0) ? -den : den;
      q  = nm / dm;
      if (q > QMAX) q = QMAX;
      return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    // Entry and exit parameters of one axis; planes swap on a negative direction.
    function void axis_span(logic signed [31:0] lo, logic signed [31:0] hi,
                            logic signed [31:0] o, logic signed [31:0] d,
                            output longint tn, output longint tf);
      longint a, b;
      a = longint'(lo) - longint'(o);
      b = longint'(hi) - longint'(o);
      if (d >= 0) begin
        tn = quotient(a, d);
        tf = quotient(b, d);
      end else begin
        tn = quotient(b, d);
        tf = quotient(a, d);
      end
    endfunction

    function void note_ray(ray_t r);
      longint xn, xf, yn, yf, zn, zf, tn, tf, res;
      hit_t   h;
      h.hit = 1'b0;
      res   = 0;
      axis_span(corner[REG_MIN_X], corner[REG_MAX_X], r.org_x, r.dir_x, xn, xf);
      axis_span(corner[REG_MIN_Y], corner[REG_MAX_Y], r.org_y, r.dir_y, yn, yf);
      if (!(xn > yf || yn > xf)) begin
        tn = (yn > xn) ? yn : xn;
        tf = (yf < xf) ? yf : xf;
        axis_span(corner[REG_MIN_Z], corner[REG_MAX_Z], r.org_z, r.dir_z, zn, zf);
        if (!(tn > zf || zn > tf)) begin
          if (zn > tn) tn = zn;
          if (zf < tf) tf = zf;
          // Entry ahead of the origin, else exit when the origin is inside.
          if (tf > 0 && tn > 0) begin
            h.hit = 1'b1;
            res   = tn;
          end else if (tf > 0) begin
            h.hit = 1'b1;
            res   = tf;
          end
        end
      end
      if (res > 64'sh7FFF_FFFF) res = 64'sh7FFF_FFFF;
      h.distance = h.hit ? res[30:0] : '0;
      pending.push_back(h);
    endfunction

    function void check_result(logic hit, logic [30:0] distance);
      hit_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result hit=%0b distance=%0h", $time, hit, distance);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (hit !== e.hit) begin
        $display("%0t: hit expected %0b actual %0b", $time, e.hit, hit);
        errors++;
      end
      if (distance !== e.distance) begin
        $display("%0t: distance expected %0h actual %0h", $time, e.distance, distance);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic wr_en;
  logic [IDX_W-1:0] wr_index;
  logic [CW-1:0]    wr_data;

  rbsi_ray_if ray ();
  rbsi_hit_if result ();

  ray_box_slab_intersect i_dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .ray      (ray.sink),
    .result   (result.source)
  );

  hit_scoreboard sb = new();

  int unsigned send_idle_pct  = 0;
  int unsigned stall_pct      = 0;
  int unsigned hold_token     = 0;
  int unsigned hold_seen      = 0;
  int unsigned hold_left      = 0;
  int unsigned cycle_count    = 0;

  always #10 clk = ~clk;

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else if (hold_token != hold_seen) begin
      hold_seen    <= hold_token;
      hold_left    <= 400;
      result.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      result.ready <= 1'b0;
    end else begin
      result.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst && result.valid && result.ready)
      sb.check_result(result.hit, result.distance);
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_CAP) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Offers one request and holds it until accepted, with optional idle cycles first.
  task automatic send_ray(ray_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      ray.valid <= 1'b0;
      @(posedge clk);
    end
    ray.valid    <= 1'b1;
    ray.dir_x    <= r.dir_x;
    ray.dir_y    <= r.dir_y;
    ray.dir_z    <= r.dir_z;
    ray.origin_x <= r.org_x;
    ray.origin_y <= r.org_y;
    ray.origin_z <= r.org_z;
    do @(posedge clk); while (!ray.ready);
    sb.note_ray(r);
  endtask

  task automatic drain();
    ray.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // One register write, then wr_en is dropped again before the task returns.
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CW-1:0] val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
    sb.write_corner(idx, val);
    wr_en    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_box(logic [CW-1:0] mnx, logic [CW-1:0] mny, logic [CW-1:0] mnz,
                         logic [CW-1:0] mxx, logic [CW-1:0] mxy, logic [CW-1:0] mxz);
    write_reg(REG_MIN_X, mnx);
    write_reg(REG_MIN_Y, mny);
    write_reg(REG_MIN_Z, mnz);
    write_reg(REG_MAX_X, mxx);
    write_reg(REG_MAX_Y, mxy);
    write_reg(REG_MAX_Z, mxz);
  endtask

  function automatic logic [31:0] near_coord(int span);
    return 32'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic ray_t make_ray(logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                                    logic [31:0] ox, logic [31:0] oy, logic [31:0] oz);
    ray_t r;
    r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
    r.org_x = ox; r.org_y = oy; r.org_z = oz;
    return r;
  endfunction

  // Mostly rays aimed through (or, for some, away from) a point of the box; the rest fully random.
  function automatic ray_t random_ray();
    ray_t        r;
    logic [31:0] tgt[3], org[3], d[3];
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 20) begin
      return make_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end
    for (int a = 0; a < 3; a++) begin
      tgt[a] = sb.corner[a] + 32'(($urandom_range(0, 255) *
               (longint'(sb.corner[a + 3]) - longint'(sb.corner[a]))) / 255);
      org[a] = (pick < 35) ? tgt[a] + near_coord(65536)
                           : tgt[a] + near_coord(40 * 65536);
      d[a]   = tgt[a] - org[a];
      if (pick >= 90) d[a] = -d[a];
      if ($urandom_range(19) == 0) d[a] = '0;
    end
    return make_ray(d[0], d[1], d[2], org[0], org[1], org[2]);
  endfunction

  task automatic set_idle_mode(int m);
    case (m)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 62; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 62; end
      default: begin send_idle_pct = 23; stall_pct = 23; end
    endcase
  endtask

  localparam logic [31:0] MAXP = 32'h7FFF_FFFF;
  localparam logic [31:0] MINN = 32'h8000_0000;
  localparam logic [31:0] HALF = 32'h0000_8000;
  localparam logic [31:0] NEG1 = 32'hFFFF_0000;

  initial begin
    rst       <= 1'b1;
    wr_en     <= 1'b0;
    wr_index  <= '0;
    wr_data   <= '0;
    ray.valid <= 1'b0;
    ray.dir_x <= '0; ray.dir_y <= '0; ray.dir_z <= '0;
    ray.origin_x <= '0; ray.origin_y <= '0; ray.origin_z <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests against the unit cube at reset.
    send_ray(make_ray(ONE_FX, 0, 0, NEG1, HALF, HALF));          // entry hit along x
    send_ray(make_ray(NEG1, 0, 0, 32'h0002_0000, HALF, HALF));   // negative direction
    send_ray(make_ray(ONE_FX, ONE_FX, ONE_FX, HALF, HALF, HALF));// origin inside
    send_ray(make_ray(ONE_FX, 0, 0, 32'h0002_0000, HALF, HALF)); // box behind
    send_ray(make_ray(0, 0, 0, HALF, HALF, HALF));               // all-zero direction
    send_ray(make_ray(0, ONE_FX, 0, NEG1, NEG1, HALF));          // zero dir outside slab
    send_ray(make_ray(ONE_FX, ONE_FX, 0, NEG1, 32'h0003_0000, HALF)); // miss between slabs
    send_ray(make_ray(MAXP, MAXP, MAXP, MINN, MINN, MINN));
    send_ray(make_ray(MINN, MINN, MINN, MAXP, MAXP, MAXP));
    send_ray(make_ray(1, 1, 1, MINN, MINN, MINN));               // saturated quotients
    send_ray(make_ray(32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, MAXP, 0, MAXP));
    send_ray(make_ray(ONE_FX, 0, 0, 0, HALF, HALF));             // origin on a face
    send_ray(make_ray(ONE_FX, 0, 0, NEG1, 0, 0));                // grazing an edge
    send_ray(make_ray(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_ray(make_ray(0, 0, 0, 0, 0, 0));
    drain();

    // Extreme box, then an ignored write to an unused index.
    set_box(MINN, MINN, MINN, MAXP, MAXP, MAXP);
    write_reg(3'd7, 32'h1234_5678);
    send_ray(make_ray(ONE_FX, ONE_FX, ONE_FX, 0, 0, 0));
    send_ray(make_ray(MAXP, MINN, 1, MINN, MAXP, 0));
    send_ray(make_ray(0, 0, 0, MAXP, MINN, MAXP));
    drain();
    // Inverted box.
    set_box(ONE_FX, ONE_FX, ONE_FX, 0, 0, 0);
    send_ray(make_ray(ONE_FX, ONE_FX, ONE_FX, NEG1, NEG1, NEG1));
    send_ray(make_ray(NEG1, 0, 0, HALF, HALF, HALF));
    drain();

    // Random phases over several boxes and idling modes.
    for (int p = 0; p < 8; p++) begin
      logic [31:0] lo[3], hi[3];
      drain();
      for (int a = 0; a < 3; a++) begin
        lo[a] = near_coord(10 * 65536);
        hi[a] = lo[a] + $urandom_range(0, 8 * 65536);
      end
      if (p == 5) begin
        lo[0] = MINN; hi[0] = MAXP;
      end
      if (p == 6) begin
        logic [31:0] t;
        t = lo[1]; lo[1] = hi[1]; hi[1] = t;
      end
      set_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
      set_idle_mode(p % 4);
      for (int n = 0; n < 240; n++) begin
        if (p == 2 && n == 20) hold_token = hold_token + 1;
        if (p == 3 && n == 120) drain();
        send_ray(random_ray());
      end
    end
    drain();

    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/rbsi_pkg.sv
hdl/rbsi_ray_if.sv
hdl/rbsi_hit_if.sv
hdl/rbsi_div.sv
hdl/rbsi_lane.sv
hdl/rbsi_merge.sv
hdl/ray_box_slab_intersect.sv
tb/tb_ray_box_slab_intersect.sv
